// ===== rtl/aab_pkg.sv =====
// shared types and constants for the ambient auto brightness block
// no dependencies; imported by aab_alu and ambient_auto_brightness
package aab_pkg;

  localparam int unsigned ALU_W = 32;

  // timing constants in milliseconds
  localparam int unsigned BLANK_SETTLE_MS = 10;
  localparam int unsigned UPDATE_MS       = 200;
  localparam int unsigned MIN_INTERVAL_MS = 10000;
  localparam int unsigned MS_PER_S        = 1000;

  // level stepping
  localparam int unsigned LVL_STEP     = 2;
  localparam int unsigned LVL_DEADBAND = 3;

  // config register indexes, byte address is 4 * index
  typedef enum logic [2:0] {
    REG_MODE      = 3'd0,
    REG_MANUAL    = 3'd1,
    REG_FLOOR     = 3'd2,
    REG_CEIL      = 3'd3,
    REG_BLANK_EN  = 3'd4,
    REG_BLANK_IVL = 3'd5
  } reg_idx_t;

  // request to the shared adder: y = a + (inv_b ? ~b : b) + cin
  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             inv_b;
    logic             cin;
  } alu_req_t;

endpackage

// ===== rtl/aab_alu.sv =====
// shared 32-bit add/subtract unit used by the arithmetic steps of the sequencer
// depends on aab_pkg for the request struct and width
module aab_alu
  import aab_pkg::*;
(
  input  alu_req_t         req,
  output logic [ALU_W-1:0] y
);

  logic [ALU_W-1:0] b_eff;

  assign b_eff = req.inv_b ? ~req.b : req.b;
  assign y     = req.a + b_eff + ALU_W'(req.cin);

endmodule

// ===== rtl/ambient_auto_brightness.sv =====
// top level of the ambient auto brightness controller: apb registers, sequencer, result register
// depends on aab_pkg and aab_alu
//
// One item is one update call (timestamp plus light sample) and gives exactly one result item.
// Item arithmetic runs through a single shared 32-bit adder stepped by a small sequencer, so the
// block takes one item at a time and in_ready is low while an item is being worked.
// The path from acceptance to a valid result is shortest in manual mode, longer for blanking
// events and for calls inside the 200 ms update window, and longest for a full brightness update,
// most of which is the 8-step shift-add multiply of the smoothed light by the level range.
// The done state loads the result only once an earlier result has been taken, and in_ready
// returns as the new result becomes valid.
// The result register frees the input side, so a new item can be taken while a result waits.
// Configuration registers sit at byte address 4 * index and must only be written while idle.
module ambient_auto_brightness
  import aab_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now_ms,
  input  logic [11:0] in_light_sample,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_brightness,
  output logic        out_brightness_set,
  output logic        out_blank_leds,
  output logic        out_restore_leds,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int SB       = SAMPLE_BITS;
  localparam int EXTW     = (SB > 12) ? SB : 12;
  localparam int IVW      = 18;
  localparam logic [SB-1:0] SAMPLE_MID = SB'(1) << (SB - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MODE, S_BLK, S_BUSY, S_UPD, S_FDIFF, S_FADD, S_SLOW1,
    S_SLOW2, S_RANGE, S_MUL, S_DIV, S_TGT, S_DIFF, S_STEP, S_DONE
  } state_t;

  // configuration registers
  logic       mode_r;
  logic [7:0] manual_r;
  logic [7:0] floor_r;
  logic [7:0] ceil_r;
  logic       blank_en_r;
  logic [7:0] bis_r;

  // persistent state
  logic [7:0]    applied_r;
  logic [31:0]   last_upd_r;
  logic [31:0]   last_blank_r;
  logic          busy_r;
  logic [31:0]   blank_start_r;
  logic [SB-1:0] dark_r;
  logic          dvalid_r;
  logic [SB-1:0] avg_r;
  logic [SB-1:0] slow_r;

  // working registers for one item
  state_t           state_r;
  logic [31:0]      now_r;
  logic [SB-1:0]    smp_r;
  logic [SB-1:0]    lvl_r;
  logic [ALU_W-1:0] acc_r;
  logic [7:0]       rng_r;
  logic [7:0]       tgt_r;
  logic [2:0]       mul_cnt_r;
  logic             step_up_r;
  logic             set_r;
  logic             blank_r;
  logic             restore_r;

  // result register
  logic       out_valid_r;
  logic [7:0] out_level_r;
  logic       out_set_r;
  logic       out_blank_r;
  logic       out_restore_r;

  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_y;
  logic [IVW-1:0]   ivl_raw;
  logic [IVW-1:0]   ivl_ms;
  logic [EXTW-1:0]  smp_ext;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;
  logic             in_fire;
  logic signed [ALU_W-1:0] diff_s;
  logic [7:0]       step_lvl;
  logic [7:0]       clamp_lo;

  aab_alu u_alu (
    .req (alu_req),
    .y   (alu_y)
  );

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign smp_ext  = EXTW'(in_light_sample);

  // blanking interval in ms, raised to the minimum
  assign ivl_raw = IVW'(bis_r) * IVW'(MS_PER_S);
  assign ivl_ms  = (ivl_raw < IVW'(MIN_INTERVAL_MS)) ? IVW'(MIN_INTERVAL_MS) : ivl_raw;

  assign diff_s   = $signed(alu_y);
  assign step_lvl = alu_y[7:0];
  assign clamp_lo = (step_lvl < floor_r) ? floor_r : step_lvl;

  // operand selection for the shared adder
  always_comb begin
    alu_req = '0;
    case (state_r)
      S_BLK: begin
        alu_req.a     = now_r;
        alu_req.b     = last_blank_r;
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      S_BUSY: begin
        alu_req.a     = now_r;
        alu_req.b     = blank_start_r;
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      S_UPD: begin
        alu_req.a     = now_r;
        alu_req.b     = last_upd_r;
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      S_FDIFF: begin
        alu_req.a     = ALU_W'(smp_r);
        alu_req.b     = ALU_W'(avg_r);
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      S_FADD: begin
        // arithmetic shift gives the floored 1/16 step
        alu_req.a = ALU_W'(avg_r);
        alu_req.b = {{4{acc_r[ALU_W-1]}}, acc_r[ALU_W-1:4]};
      end
      S_SLOW1: begin
        alu_req.a     = ALU_W'(slow_r) << 5;
        alu_req.b     = ALU_W'(slow_r);
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      S_SLOW2: begin
        alu_req.a = acc_r;
        alu_req.b = ALU_W'(lvl_r);
      end
      S_RANGE: begin
        alu_req.a     = ALU_W'(ceil_r);
        alu_req.b     = ALU_W'(floor_r);
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      S_MUL: begin
        alu_req.a = acc_r;
        alu_req.b = rng_r[mul_cnt_r] ? (ALU_W'(slow_r) << mul_cnt_r) : '0;
      end
      S_DIV: begin
        // x / (2^SB - 1) as (x + (x >> SB) + 1) >> SB, exact for x below 2^(2*SB) - 1
        alu_req.a   = acc_r;
        alu_req.b   = acc_r >> SB;
        alu_req.cin = 1'b1;
      end
      S_TGT: begin
        alu_req.a = ALU_W'(floor_r);
        alu_req.b = ALU_W'(tgt_r);
      end
      S_DIFF: begin
        alu_req.a     = ALU_W'(tgt_r);
        alu_req.b     = ALU_W'(applied_r);
        alu_req.inv_b = 1'b1;
        alu_req.cin   = 1'b1;
      end
      S_STEP: begin
        alu_req.a     = ALU_W'(applied_r);
        alu_req.b     = ALU_W'(LVL_STEP);
        alu_req.inv_b = !step_up_r;
        alu_req.cin   = !step_up_r;
      end
      default: alu_req = '0;
    endcase
  end

  // apb register file
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      manual_r   <= 8'd30;
      floor_r    <= 8'd10;
      ceil_r     <= 8'd255;
      blank_en_r <= 1'b0;
      bis_r      <= 8'd30;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:      mode_r     <= cfg_pwdata[0];
        REG_MANUAL:    manual_r   <= cfg_pwdata[7:0];
        REG_FLOOR:     floor_r    <= cfg_pwdata[7:0];
        REG_CEIL:      ceil_r     <= cfg_pwdata[7:0];
        REG_BLANK_EN:  blank_en_r <= cfg_pwdata[0];
        REG_BLANK_IVL: bis_r      <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MODE:      cfg_prdata = 32'(mode_r);
      REG_MANUAL:    cfg_prdata = 32'(manual_r);
      REG_FLOOR:     cfg_prdata = 32'(floor_r);
      REG_CEIL:      cfg_prdata = 32'(ceil_r);
      REG_BLANK_EN:  cfg_prdata = 32'(blank_en_r);
      REG_BLANK_IVL: cfg_prdata = 32'(bis_r);
      default:       cfg_prdata = '0;
    endcase
  end

  // sequencer, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      applied_r     <= 8'd30;
      last_upd_r    <= '0;
      last_blank_r  <= '0;
      busy_r        <= 1'b0;
      blank_start_r <= '0;
      dark_r        <= '0;
      dvalid_r      <= 1'b0;
      avg_r         <= '0;
      slow_r        <= SAMPLE_MID;
      out_valid_r   <= 1'b0;
    end else begin
      // the done state reloads the result register itself
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            now_r     <= in_now_ms;
            smp_r     <= smp_ext[SB-1:0];
            set_r     <= 1'b0;
            blank_r   <= 1'b0;
            restore_r <= 1'b0;
            state_r   <= S_MODE;
          end
        end
        S_MODE: begin
          if (mode_r) begin
            if (applied_r != manual_r) begin
              applied_r <= manual_r;
              set_r     <= 1'b1;
            end
            state_r <= S_DONE;
          end else begin
            state_r <= S_BLK;
          end
        end
        S_BLK: begin
          if (blank_en_r && !busy_r && (alu_y > 32'(ivl_ms))) begin
            busy_r        <= 1'b1;
            blank_start_r <= now_r;
            blank_r       <= 1'b1;
            state_r       <= S_DONE;
          end else if (busy_r) begin
            state_r <= S_BUSY;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_BUSY: begin
          if (alu_y >= 32'(BLANK_SETTLE_MS)) begin
            dark_r       <= smp_r;
            dvalid_r     <= 1'b1;
            busy_r       <= 1'b0;
            last_blank_r <= now_r;
            restore_r    <= 1'b1;
          end
          state_r <= S_DONE;
        end
        S_UPD: begin
          if (alu_y < 32'(UPDATE_MS)) begin
            state_r <= S_DONE;
          end else begin
            last_upd_r <= now_r;
            if (blank_en_r && dvalid_r) begin
              lvl_r   <= dark_r;
              state_r <= S_SLOW1;
            end else if (avg_r == '0) begin
              // empty average is seeded with the sample
              avg_r   <= smp_r;
              lvl_r   <= smp_r;
              state_r <= S_SLOW1;
            end else begin
              state_r <= S_FDIFF;
            end
          end
        end
        S_FDIFF: begin
          acc_r   <= alu_y;
          state_r <= S_FADD;
        end
        S_FADD: begin
          avg_r   <= alu_y[SB-1:0];
          lvl_r   <= alu_y[SB-1:0];
          state_r <= S_SLOW1;
        end
        S_SLOW1: begin
          acc_r   <= alu_y;
          state_r <= S_SLOW2;
        end
        S_SLOW2: begin
          slow_r  <= alu_y[SB+4:5];
          state_r <= S_RANGE;
        end
        S_RANGE: begin
          // ceiling below floor or no light maps to the floor
          if (alu_y[ALU_W-1] || (slow_r == '0)) begin
            tgt_r   <= floor_r;
            state_r <= S_DIFF;
          end else begin
            rng_r     <= alu_y[7:0];
            acc_r     <= '0;
            mul_cnt_r <= '0;
            state_r   <= S_MUL;
          end
        end
        S_MUL: begin
          acc_r     <= alu_y;
          mul_cnt_r <= mul_cnt_r + 3'd1;
          if (mul_cnt_r == 3'd7) begin
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          tgt_r   <= alu_y[SB+7:SB];
          state_r <= S_TGT;
        end
        S_TGT: begin
          tgt_r   <= alu_y[7:0];
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          if ((diff_s > -$signed(ALU_W'(LVL_DEADBAND))) &&
              (diff_s < $signed(ALU_W'(LVL_DEADBAND)))) begin
            state_r <= S_DONE;
          end else begin
            step_up_r <= !diff_s[ALU_W-1];
            state_r   <= S_STEP;
          end
        end
        S_STEP: begin
          applied_r <= (clamp_lo > ceil_r) ? ceil_r : clamp_lo;
          set_r     <= 1'b1;
          state_r   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r   <= 1'b1;
            out_level_r   <= applied_r;
            out_set_r     <= set_r;
            out_blank_r   <= blank_r;
            out_restore_r <= restore_r;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_brightness     = out_level_r;
  assign out_brightness_set = out_set_r;
  assign out_blank_leds     = out_blank_r;
  assign out_restore_leds   = out_restore_r;

  // an accepted item always takes the sequencer out of idle
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("in_ready still high after an item was accepted");

  // a result carries at most one event
  a_one_event : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $onehot0({out_set_r, out_blank_r, out_restore_r}))
    else $error("result carries more than one event");

  // blanking only starts while enabled
  a_blank_enabled : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> $past(blank_en_r))
    else $error("blanking started while disabled");

  // a restore always leaves a dark reading behind
  a_restore_dark : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_restore_r) |-> dvalid_r)
    else $error("restore without a dark reading");

  // the multiply only runs in automatic mode
  a_mul_auto : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> !mode_r)
    else $error("level multiply running in manual mode");

endmodule
